// ===== rtl/ubs_pkg.sv =====
// Shared types and constants for the UTF-8 byte sanitizer.
package ubs_pkg;

  localparam logic [7:0] REPL_0 = 8'hEF;
  localparam logic [7:0] REPL_1 = 8'hBF;
  localparam logic [7:0] REPL_2 = 8'hBD;

  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_TAG  = 8'hF0;

  // Command for the back end: rep_cnt replacement triples, then dat_cnt data bytes.
  typedef struct packed {
    logic [2:0]      rep_cnt;
    logic [2:0]      dat_cnt;
    logic [3:0][7:0] dat;
    logic            last;
  } cmd_t;

  function automatic logic [7:0] repl_byte(input logic [1:0] sel);
    logic [7:0] r;
    case (sel)
      2'd0: r = REPL_0;
      2'd1: r = REPL_1;
      default: r = REPL_2;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/ubs_front.sv =====
// Front end: classifies each input byte, tracks the held sequence, issues commands.
module ubs_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                string_last,
  input  logic                q_full,
  output logic                q_push,
  output ubs_pkg::cmd_t       q_cmd
);

  logic [2:0][7:0] held_bytes;
  logic [1:0]      held_count;
  logic [2:0]      sequence_length;

  logic [2:0][7:0] held_bytes_next;
  logic [1:0]      held_count_next;
  logic [2:0]      sequence_length_next;

  logic       active;
  logic       is_cont;
  logic       complete;
  logic [2:0] lead_len;
  logic [2:0] reps;
  logic       accept;
  ubs_pkg::cmd_t cmd;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign active   = sequence_length != 3'd0;
  assign is_cont  = (in_byte & ubs_pkg::CONT_MASK) == ubs_pkg::CONT_TAG;
  assign complete = (({1'b0, held_count} + 3'd1) >= sequence_length) || (held_count == 2'd3);

  always_comb begin
    if ((in_byte & ubs_pkg::LEAD2_MASK) == ubs_pkg::LEAD2_TAG) begin
      lead_len = 3'd2;
    end else if ((in_byte & ubs_pkg::LEAD3_MASK) == ubs_pkg::LEAD3_TAG) begin
      lead_len = 3'd3;
    end else if ((in_byte & ubs_pkg::LEAD4_MASK) == ubs_pkg::LEAD4_TAG) begin
      lead_len = 3'd4;
    end else begin
      lead_len = 3'd0;
    end
  end

  always_comb begin
    held_bytes_next      = held_bytes;
    held_count_next      = held_count;
    sequence_length_next = sequence_length;
    reps                 = 3'd0;
    cmd.dat              = '0;
    cmd.dat_cnt          = 3'd0;
    cmd.last             = string_last;

    if (active && is_cont) begin
      if (complete) begin
        cmd.dat[0]             = held_bytes[0];
        cmd.dat[1]             = held_bytes[1];
        cmd.dat[2]             = held_bytes[2];
        cmd.dat[held_count]    = in_byte;
        cmd.dat_cnt            = {1'b0, held_count} + 3'd1;
        held_count_next        = 2'd0;
        sequence_length_next   = 3'd0;
      end else begin
        held_bytes_next[held_count] = in_byte;
        held_count_next             = held_count + 2'd1;
      end
    end else begin
      if (active) begin
        reps = {1'b0, held_count};
      end
      held_count_next      = 2'd0;
      sequence_length_next = 3'd0;
      if (!in_byte[7]) begin
        cmd.dat[0]  = in_byte;
        cmd.dat_cnt = 3'd1;
      end else if (lead_len == 3'd0) begin
        reps = reps + 3'd1;
      end else begin
        held_bytes_next[0]   = in_byte;
        held_count_next      = 2'd1;
        sequence_length_next = lead_len;
      end
    end

    if (string_last) begin
      if (sequence_length_next != 3'd0) begin
        reps = reps + {1'b0, held_count_next};
      end
      held_count_next      = 2'd0;
      sequence_length_next = 3'd0;
    end

    cmd.rep_cnt = reps;
  end

  assign q_cmd  = cmd;
  assign q_push = accept && ((cmd.rep_cnt != 3'd0) || (cmd.dat_cnt != 3'd0));

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count      <= 2'd0;
      sequence_length <= 3'd0;
    end else if (accept) begin
      held_count      <= held_count_next;
      sequence_length <= sequence_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_bytes <= held_bytes_next;
    end
  end

endmodule

// ===== rtl/ubs_cmd_fifo.sv =====
// Two-entry command queue between front and back ends.
module ubs_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ubs_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output ubs_pkg::cmd_t pop_cmd,
  output logic          empty
);

  ubs_pkg::cmd_t [1:0] entries;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = count == 2'd2;
  assign empty   = count == 2'd0;
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== rtl/ubs_back.sv =====
// Back end: expands commands into output beats through an output register.
module ubs_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  ubs_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          run_last,
  output logic          string_end
);

  ubs_pkg::cmd_t cur;
  logic       busy;
  logic [2:0] rep_left;
  logic [1:0] sub;
  logic [1:0] idx;

  logic       advance;
  logic       final_beat;
  logic [7:0] beat_byte;

  assign advance = busy && (!out_valid || out_ready);

  always_comb begin
    if (rep_left != 3'd0) begin
      beat_byte  = ubs_pkg::repl_byte(sub);
      final_beat = (rep_left == 3'd1) && (sub == 2'd2) && (cur.dat_cnt == 3'd0);
    end else begin
      beat_byte  = cur.dat[idx];
      final_beat = ({1'b0, idx} + 3'd1) == cur.dat_cnt;
    end
  end

  assign q_pop = !q_empty && (!busy || (advance && final_beat));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (q_pop) begin
      busy <= 1'b1;
    end else if (advance && final_beat) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur      <= q_cmd;
      rep_left <= q_cmd.rep_cnt;
      sub      <= 2'd0;
      idx      <= 2'd0;
    end else if (advance) begin
      if (rep_left != 3'd0) begin
        if (sub == 2'd2) begin
          sub      <= 2'd0;
          rep_left <= rep_left - 3'd1;
        end else begin
          sub <= sub + 2'd1;
        end
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte   <= beat_byte;
      run_last   <= final_beat;
      string_end <= final_beat && cur.last;
    end
  end

endmodule

// ===== rtl/utf8_byte_sanitizer.sv =====
// Top level of the UTF-8 byte sanitizer: front end, command queue, back end.
//
// Input channel: one raw byte per beat (in_byte) with string_last on the
// final byte of each string. Output channel: cleaned bytes (out_byte), with
// run_last on the last beat caused by one input beat and string_end on the
// final beat of each cleaned string.
// The front end takes one input beat per cycle while the two-entry command
// queue has room; bytes that only extend a held sequence produce no output.
// The back end sends one output beat per cycle while out_ready is high, so an
// input beat that yields k output beats (k up to 12; a replacement character
// is three beats) holds the back end until all k are sent. The back end's
// one-beat-per-cycle pace sets the sustained input rate whenever replacements
// or completed sequences pile up. With the back end idle, the first output
// beat of an input beat goes through a queue entry and the output register.
// A stalled receiver holds the output register; the queue then fills and
// in_ready drops. Reset drops any held sequence and queued work and clears
// out_valid.
module utf8_byte_sanitizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       string_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       string_end
);

  logic          q_full;
  logic          q_empty;
  logic          q_push;
  logic          q_pop;
  ubs_pkg::cmd_t push_cmd;
  ubs_pkg::cmd_t pop_cmd;

  ubs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .string_last (string_last),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (push_cmd)
  );

  ubs_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  ubs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_cmd      (pop_cmd),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .string_end (string_end)
  );

endmodule
